// ===== rtl/tcr_pkg.sv =====
// Package for the token class recognizer: character codes, limits and class codes.
// It depends on nothing else. The module token_class_recognizer imports it.
`default_nettype none

package tcr_pkg;

	// Character codes, in ASCII.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	// Position limits and the places of the GUID separators.
	localparam int POS_W = 6;
	localparam logic [POS_W-1:0] POS_MAX  = 6'd37;
	localparam logic [POS_W-1:0] GUID_LEN = 6'd36;
	localparam logic [POS_W-1:0] GUID_SEP0 = 6'd8;
	localparam logic [POS_W-1:0] GUID_SEP1 = 6'd13;
	localparam logic [POS_W-1:0] GUID_SEP2 = 6'd18;
	localparam logic [POS_W-1:0] GUID_SEP3 = 6'd23;

	// Dot counter saturates at two.
	localparam logic [1:0] DOTS_NONE = 2'd0;
	localparam logic [1:0] DOTS_ONE  = 2'd1;
	localparam logic [1:0] DOTS_MANY = 2'd2;

	// Class codes on the result channel.
	typedef enum logic [2:0] {
		CLS_NEG_INT   = 3'd0,
		CLS_INT       = 3'd1,
		CLS_GUID      = 3'd2,
		CLS_BINARY    = 3'd3,
		CLS_FLOAT     = 3'd4,
		CLS_NEG_FLOAT = 3'd5,
		CLS_UNKNOWN   = 3'd6
	} tok_class_t;

	// Per-token scan state.
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             lead_minus;
		logic             body_all_digits;
		logic             body_has_digit;
		logic             body_digits_or_dot;
		logic [1:0]       dot_count;
		logic             digit_before_dot;
		logic             digit_after_dot;
		logic             prev_was_digit;
		logic             guid_valid;
		logic             binary_valid;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		position:           '0,
		lead_minus:         1'b0,
		body_all_digits:    1'b1,
		body_has_digit:     1'b0,
		body_digits_or_dot: 1'b1,
		dot_count:          DOTS_NONE,
		digit_before_dot:   1'b0,
		digit_after_dot:    1'b0,
		prev_was_digit:     1'b0,
		guid_valid:         1'b1,
		binary_valid:       1'b1
	};

endpackage

`default_nettype wire

// ===== rtl/token_class_recognizer.sv =====
// Token class recognizer: scans a token one character per beat and classifies it.
// Depends on tcr_pkg for character codes, class codes and the scan state type.
//
// A token enters one character per input beat, with last_char set on its final
// character. The scan flags are updated in the cycle the beat is accepted, and
// on the final character the class code is loaded into the output register and
// shown on the next cycle. A new character is accepted in every cycle while the
// output register is empty or being read, so tokens follow each other with no
// gap. Only the final character of a token produces an output beat; the scan
// state then returns to its reset value.
`default_nettype none

module token_class_recognizer
	import tcr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      token_class
);

	scan_t      scan_q;
	scan_t      scan_nxt;
	logic       out_valid_q;
	tok_class_t class_q;
	tok_class_t class_nxt;
	logic       accept;
	logic       is_dig;
	logic       is_hex;
	logic       is_sep_pos;
	logic       float_ok;
	logic       int_body;

	// The output register is free when empty or being drained this cycle.
	assign in_ready    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign token_class = class_q;

	// Character classes.
	always_comb begin
		is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_hex = is_dig || ((ch >= CH_LOW_A) && (ch <= CH_LOW_F))
			|| ((ch >= CH_UP_A) && (ch <= CH_UP_F));
		is_sep_pos = (scan_q.position == GUID_SEP0) || (scan_q.position == GUID_SEP1)
			|| (scan_q.position == GUID_SEP2) || (scan_q.position == GUID_SEP3);
	end

	// Next scan state from the current character.
	always_comb begin
		scan_nxt = scan_q;

		// GUID: separators at fixed places, hex digits elsewhere, 36 characters.
		if (scan_q.position >= GUID_LEN) begin
			scan_nxt.guid_valid = 1'b0;
		end else if (is_sep_pos) begin
			if (ch != CH_MINUS) scan_nxt.guid_valid = 1'b0;
		end else if (!is_hex) begin
			scan_nxt.guid_valid = 1'b0;
		end

		// Binary: a "0b" prefix followed by ones and zeros.
		if (scan_q.position == '0) begin
			if (ch != CH_ZERO) scan_nxt.binary_valid = 1'b0;
		end else if (scan_q.position == POS_W'(1)) begin
			if (ch != CH_LOW_B) scan_nxt.binary_valid = 1'b0;
		end else if ((ch != CH_ZERO) && (ch != CH_ONE)) begin
			scan_nxt.binary_valid = 1'b0;
		end

		// Integer and float body, after an optional leading minus.
		if ((scan_q.position == '0) && (ch == CH_MINUS)) begin
			scan_nxt.lead_minus     = 1'b1;
			scan_nxt.prev_was_digit = 1'b0;
		end else begin
			if (is_dig) begin
				scan_nxt.body_has_digit = 1'b1;
				if (scan_q.dot_count == DOTS_ONE) scan_nxt.digit_after_dot = 1'b1;
			end else begin
				scan_nxt.body_all_digits = 1'b0;
				if (ch == CH_DOT) begin
					if (scan_q.prev_was_digit && (scan_q.dot_count == DOTS_NONE)) begin
						scan_nxt.digit_before_dot = 1'b1;
					end
					if (scan_q.dot_count != DOTS_MANY) begin
						scan_nxt.dot_count = scan_q.dot_count + 2'd1;
					end
				end else begin
					scan_nxt.body_digits_or_dot = 1'b0;
				end
			end
			scan_nxt.prev_was_digit = is_dig;
		end

		// Position saturates one past the GUID length.
		if (scan_q.position < POS_MAX) scan_nxt.position = scan_q.position + POS_W'(1);
	end

	// Class in priority order, from the updated flags and the old position.
	always_comb begin
		float_ok = scan_nxt.body_digits_or_dot && (scan_nxt.dot_count == DOTS_ONE)
			&& scan_nxt.digit_before_dot && scan_nxt.digit_after_dot;
		int_body = scan_nxt.body_all_digits && scan_nxt.body_has_digit;
		if (int_body && scan_nxt.lead_minus) begin
			class_nxt = CLS_NEG_INT;
		end else if (int_body) begin
			class_nxt = CLS_INT;
		end else if (scan_nxt.guid_valid && (scan_q.position == GUID_LEN - POS_W'(1))) begin
			class_nxt = CLS_GUID;
		end else if (scan_nxt.binary_valid && (scan_q.position >= POS_W'(2))) begin
			class_nxt = CLS_BINARY;
		end else if (float_ok && !scan_nxt.lead_minus) begin
			class_nxt = CLS_FLOAT;
		end else if (float_ok) begin
			class_nxt = CLS_NEG_FLOAT;
		end else begin
			class_nxt = CLS_UNKNOWN;
		end
	end

	// Scan state: updated on each accepted beat, cleared after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SCAN_RESET;
		end else if (accept) begin
			scan_q <= last_char ? SCAN_RESET : scan_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) class_q <= class_nxt;
	end

endmodule

`default_nettype wire
